### design/oaa_pkg.sv
`timescale 1ns / 1ps

package oaa_pkg;

  localparam int VALUE_W = 23;
  localparam int COUNT_W = 11;
  localparam int ACC_W   = 33;
  localparam int RANGE_W = 2;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 2;
  localparam int QSTEP_W = $clog2(ACC_W + 1);

  localparam int MAX_OVERSAMPLING = 1024;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_INVALID = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COUNTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_AVERAGE = 2'd2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_OVERSAMPLING  = 2'd0;
  localparam logic [IDX_W-1:0] REG_INITIAL_RANGE = 2'd1;

  // full-scale range codes
  localparam logic [RANGE_W-1:0] RANGE_256MV  = 2'd0;
  localparam logic [RANGE_W-1:0] RANGE_512MV  = 2'd1;
  localparam logic [RANGE_W-1:0] RANGE_1024MV = 2'd2;
  localparam logic [RANGE_W-1:0] RANGE_2048MV = 2'd3;

  localparam logic [CFG_W-1:0]   OVERSAMPLING_RST  = 11'd16;
  localparam logic [RANGE_W-1:0] INITIAL_RANGE_RST = RANGE_2048MV;

  localparam logic signed [VALUE_W-1:0] THRESH_512MV  = 23'sd171000;
  localparam logic signed [VALUE_W-1:0] THRESH_1024MV = 23'sd426000;
  localparam logic signed [VALUE_W-1:0] THRESH_2048MV = 23'sd683000;

  localparam logic signed [VALUE_W-1:0] AVG_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] AVG_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  function automatic logic [RANGE_W-1:0] range_for(input logic signed [VALUE_W-1:0] v);
    logic [RANGE_W-1:0] code;
    if (v < THRESH_512MV) begin
      code = RANGE_256MV;
    end else if (v < THRESH_1024MV) begin
      code = RANGE_512MV;
    end else if (v < THRESH_2048MV) begin
      code = RANGE_1024MV;
    end else begin
      code = RANGE_2048MV;
    end
    return code;
  endfunction

endpackage

### design/oaa_in_if.sv
`timescale 1ns / 1ps

interface oaa_in_if;
  import oaa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      sample_ok;
  logic signed [VALUE_W-1:0] sample_value;

  modport source (output valid, output sample_ok, output sample_value, input ready);
  modport sink   (input valid, input sample_ok, input sample_value, output ready);
endinterface

### design/oaa_out_if.sv
`timescale 1ns / 1ps

interface oaa_out_if;
  import oaa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [COUNT_W-1:0]        sample_count;
  logic signed [VALUE_W-1:0] average;
  logic                      range_changed;
  logic [RANGE_W-1:0]        range_code;

  modport source (output valid, output kind, output sample_count, output average,
                  output range_changed, output range_code, input ready);
  modport sink   (input valid, input kind, input sample_count, input average,
                  input range_changed, input range_code, output ready);
endinterface

### design/oaa_divider.sv
`timescale 1ns / 1ps

module oaa_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [oaa_pkg::ACC_W-1:0]   dividend,
  input  logic [oaa_pkg::COUNT_W-1:0]        divisor,
  output logic                               done,
  output logic signed [oaa_pkg::VALUE_W-1:0] quotient
);
  import oaa_pkg::*;

  logic               busy;
  logic [QSTEP_W-1:0] step;
  logic               neg;
  logic [ACC_W-1:0]   quot;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] dvs;

  logic [ACC_W-1:0]   mag;
  logic [COUNT_W:0]   shifted;
  logic [COUNT_W+1:0] diff;
  logic               fits;

  always_comb begin
    mag     = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
    shifted = {rem, quot[ACC_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    fits    = !diff[COUNT_W+1];
  end

  assign done = busy && (step == '0);

  // magnitude quotient, sign restored and clipped to the 23-bit range
  always_comb begin
    if (neg) begin
      if (quot > ACC_W'({1'b1, {(VALUE_W-1){1'b0}}})) begin
        quotient = AVG_MIN;
      end else begin
        quotient = VALUE_W'(-quot[VALUE_W-1:0]);
      end
    end else begin
      if (quot > ACC_W'(AVG_MAX)) begin
        quotient = AVG_MAX;
      end else begin
        quotient = quot[VALUE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= QSTEP_W'(ACC_W);
    end else if (busy) begin
      if (step != '0) begin
        step <= step - QSTEP_W'(1);
      end else begin
        busy <= 1'b0;
      end
    end
  end

  // restoring division, one quotient bit shifted in per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[ACC_W-1];
      quot <= mag;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy && (step != '0)) begin
      rem  <= fits ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      quot <= {quot[ACC_W-2:0], fits};
    end
  end

endmodule

### design/oversample_average_autorange_core.sv
`timescale 1ns / 1ps

// Autoranging oversampling averager. Each sample transfer yields exactly one result: an
// invalid sample or a counted sample gives its result in the cycle after the transfer, and
// the sample that completes a block of oversampling samples gives the average when the
// divider is done, so such an item occupies the block until then. The bit-serial restoring
// divider produces one of the 33 quotient bits per cycle; no new sample is taken while it
// runs. A new sample is taken while the output register is empty or being emptied.
// Configuration writes (index 0 oversampling, index 1 initial range) take effect at once;
// writing the initial range also loads the current range.
module oversample_average_autorange_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [oaa_pkg::IDX_W-1:0]   cfg_index,
  input  logic [oaa_pkg::CFG_W-1:0]   cfg_data,
  oaa_in_if.sink                      sample_in,
  oaa_out_if.source                   result_out
);
  import oaa_pkg::*;

  state_t                    state;
  state_t                    state_next;
  logic [CFG_W-1:0]          oversampling;
  logic [RANGE_W-1:0]        current_range;
  logic signed [ACC_W-1:0]   accumulator;
  logic [COUNT_W-1:0]        sample_counter;
  logic                      pend_changed;

  logic                      out_valid;
  logic [KIND_W-1:0]         out_kind;
  logic [COUNT_W-1:0]        out_count;
  logic signed [VALUE_W-1:0] out_avg;
  logic                      out_changed;
  logic [RANGE_W-1:0]        out_range;

  logic                      in_xfer;
  logic                      out_free;
  logic [COUNT_W-1:0]        os_eff;
  logic [RANGE_W-1:0]        new_code;
  logic                      code_changed;
  logic signed [ACC_W-1:0]   acc_sum;
  logic [COUNT_W-1:0]        cnt_inc;
  logic                      block_done;
  logic                      div_start;
  logic                      div_done;
  logic signed [VALUE_W-1:0] div_quot;

  assign out_free        = !out_valid || result_out.ready;
  assign sample_in.ready = (state == ST_IDLE) && out_free;
  assign in_xfer         = sample_in.valid && sample_in.ready;

  always_comb begin
    if (oversampling == '0) begin
      os_eff = COUNT_W'(1);
    end else if (oversampling > COUNT_W'(MAX_OVERSAMPLING)) begin
      os_eff = COUNT_W'(MAX_OVERSAMPLING);
    end else begin
      os_eff = oversampling;
    end
    new_code     = range_for(sample_in.sample_value);
    code_changed = new_code != current_range;
    acc_sum      = accumulator + {{(ACC_W-VALUE_W){sample_in.sample_value[VALUE_W-1]}},
                                  sample_in.sample_value};
    cnt_inc      = sample_counter + COUNT_W'(1);
    block_done   = cnt_inc >= os_eff;
    div_start    = in_xfer && sample_in.sample_ok && block_done;
  end

  oaa_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_sum),
    .divisor  (os_eff),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (div_start) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oversampling   <= OVERSAMPLING_RST;
      current_range  <= INITIAL_RANGE_RST;
      accumulator    <= '0;
      sample_counter <= '0;
    end else begin
      if (in_xfer && sample_in.sample_ok) begin
        current_range <= new_code;
        if (block_done) begin
          accumulator    <= '0;
          sample_counter <= '0;
        end else begin
          accumulator    <= acc_sum;
          sample_counter <= cnt_inc;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OVERSAMPLING: oversampling <= cfg_data;
          // the sensor is taken to be in the written range right away
          REG_INITIAL_RANGE: current_range <= cfg_data[RANGE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_done || in_xfer) begin
      out_valid <= !(in_xfer && div_start);
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      out_kind    <= KIND_AVERAGE;
      out_count   <= '0;
      out_avg     <= div_quot;
      out_changed <= pend_changed;
      out_range   <= current_range;
    end else if (in_xfer) begin
      pend_changed <= code_changed;
      out_avg      <= '0;
      if (!sample_in.sample_ok) begin
        out_kind    <= KIND_INVALID;
        out_count   <= '0;
        out_changed <= 1'b0;
        out_range   <= current_range;
      end else begin
        out_kind    <= KIND_COUNTED;
        out_count   <= cnt_inc;
        out_changed <= code_changed;
        out_range   <= new_code;
      end
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.kind          = out_kind;
  assign result_out.sample_count  = out_count;
  assign result_out.average       = out_avg;
  assign result_out.range_changed = out_changed;
  assign result_out.range_code    = out_range;

endmodule

### design/oaa_checker.sv
`timescale 1ns / 1ps

module oaa_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_ok,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [oaa_pkg::KIND_W-1:0]         out_kind,
  input logic [oaa_pkg::COUNT_W-1:0]        out_count,
  input logic signed [oaa_pkg::VALUE_W-1:0] out_avg,
  input logic                               out_changed
);
  import oaa_pkg::*;

  // an invalid sample reports back on the next cycle
  a_invalid_next: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_ok |=> out_valid && (out_kind == KIND_INVALID))
    else $error("invalid sample did not yield a beat-end result");

  a_invalid_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_INVALID) |->
      (out_count == '0) && (out_avg == '0) && !out_changed)
    else $error("beat-end result carries data");

  a_counted_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_COUNTED) |-> (out_count != '0) && (out_avg == '0))
    else $error("counted result has bad fields");

  a_average_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_AVERAGE) |-> (out_count == '0))
    else $error("average result carries a count");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_avg))
    else $error("stalled result changed");

endmodule

bind oversample_average_autorange_core oaa_checker u_oaa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample_in.valid),
  .in_ready    (sample_in.ready),
  .in_ok       (sample_in.sample_ok),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .out_kind    (result_out.kind),
  .out_count   (result_out.sample_count),
  .out_avg     (result_out.average),
  .out_changed (result_out.range_changed)
);
